FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/mpsm_pkg.sv
// Package with the shared types and constants of the subsequence matcher.
package mpsm_pkg;

    localparam int CHAR_W    = 8;
    localparam int COUNT_W   = 5;
    localparam int CMD_W     = 2;
    localparam int INDEX_W   = 4;
    localparam int POS_IN_W  = 4;
    localparam int LEN_IN_W  = 5;
    // Width that holds any slot count or pattern length up to 256.
    localparam int EXT_W     = 9;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_LENGTH  = 2'd1,
        CMD_TEXT    = 2'd2,
        CMD_RESTART = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_DRAIN = 2'd2,
        ST_OUT   = 2'd3
    } state_t;

    typedef struct packed {
        logic exec;
        logic scan_start;
        logic scan_issue;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic slot_last;
    } ctrl_status_t;

endpackage

FILE: rtl/core/mpsm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mpsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/mpsm_ctrl.sv
// Control state machine that sequences commands, the slot scan and the result.
module mpsm_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [mpsm_pkg::CMD_W-1:0]    command,
    output logic                          result_valid,
    input  logic                          result_stall,
    input  mpsm_pkg::ctrl_status_t        status,
    output mpsm_pkg::ctrl_cmd_t           cmd
);

    mpsm_pkg::state_t state_reg;
    mpsm_pkg::state_t state_next;
    logic             result_valid_reg;
    logic             result_valid_next;
    logic             out_busy;
    logic             accept;
    logic             is_text;

    assign out_busy = result_valid_reg && result_stall;
    assign accept   = (state_reg == mpsm_pkg::ST_IDLE) && item_valid && !out_busy;
    assign is_text  = (mpsm_pkg::command_t'(command) == mpsm_pkg::CMD_TEXT);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mpsm_pkg::ST_IDLE:
            begin
                if (accept && is_text)
                begin
                    state_next = mpsm_pkg::ST_SCAN;
                end
            end
            mpsm_pkg::ST_SCAN:
            begin
                if (status.slot_last)
                begin
                    state_next = mpsm_pkg::ST_DRAIN;
                end
            end
            mpsm_pkg::ST_DRAIN:
            begin
                state_next = mpsm_pkg::ST_OUT;
            end
            mpsm_pkg::ST_OUT:
            begin
                if (!out_busy)
                begin
                    state_next = mpsm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mpsm_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath and the input handshake.
    always_comb
    begin
        item_stall     = (state_reg != mpsm_pkg::ST_IDLE) || out_busy;
        cmd.exec       = accept && !is_text;
        cmd.scan_start = accept && is_text;
        cmd.scan_issue = (state_reg == mpsm_pkg::ST_SCAN);
        cmd.out_load   = (accept && !is_text) ||
                         ((state_reg == mpsm_pkg::ST_OUT) && !out_busy);
    end

    // The result stays valid until it is taken.
    always_comb
    begin
        result_valid_next = out_busy;
        if (cmd.out_load)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mpsm_pkg::ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

endmodule

FILE: rtl/core/mpsm_datapath.sv
// Datapath: pattern memory, per-slot length and progress, compare stage and count.
module mpsm_datapath #(
    parameter int NUM_WORDS = 16,
    parameter int WORD_LEN  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mpsm_pkg::ctrl_cmd_t               cmd,
    output mpsm_pkg::ctrl_status_t            status,
    input  logic [mpsm_pkg::CMD_W-1:0]        command,
    input  logic [mpsm_pkg::INDEX_W-1:0]      word_index,
    input  logic [mpsm_pkg::POS_IN_W-1:0]     char_pos,
    input  logic [mpsm_pkg::LEN_IN_W-1:0]     word_length,
    input  logic [mpsm_pkg::CHAR_W-1:0]       char_value,
    output logic [mpsm_pkg::COUNT_W-1:0]      match_count
);

    localparam int SLOT_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int POS_W     = (WORD_LEN > 1) ? $clog2(WORD_LEN) : 1;
    localparam int LEN_W     = $clog2(WORD_LEN + 1);
    localparam int ADDR_W    = SLOT_W + POS_W;
    localparam int RAM_DEPTH = 2 ** ADDR_W;
    localparam logic [mpsm_pkg::EXT_W-1:0] NUM_WORDS_V = mpsm_pkg::EXT_W'(NUM_WORDS);
    localparam logic [mpsm_pkg::EXT_W-1:0] WORD_LEN_V  = mpsm_pkg::EXT_W'(WORD_LEN);
    localparam logic [SLOT_W-1:0]          LAST_SLOT   = SLOT_W'(NUM_WORDS - 1);

    logic [LEN_W-1:0]                 length_reg   [NUM_WORDS];
    logic [LEN_W-1:0]                 progress_reg [NUM_WORDS];
    logic [mpsm_pkg::CHAR_W-1:0]      char_reg;
    logic [SLOT_W-1:0]                slot_reg;
    logic                             cmp_valid_reg;
    logic                             cmp_active_reg;
    logic [SLOT_W-1:0]                cmp_slot_reg;
    logic [mpsm_pkg::COUNT_W-1:0]     count_reg;
    logic [mpsm_pkg::COUNT_W-1:0]     count_next;
    logic [mpsm_pkg::COUNT_W-1:0]     result_reg;

    logic [mpsm_pkg::EXT_W-1:0]       index_ext;
    logic [mpsm_pkg::EXT_W-1:0]       pos_ext;
    logic [mpsm_pkg::EXT_W-1:0]       len_ext;
    logic [mpsm_pkg::EXT_W-1:0]       len_sat;
    logic                             index_ok;
    logic                             pos_ok;
    logic                             do_load;
    logic                             do_length;
    logic                             do_restart;
    logic [LEN_W-1:0]                 issue_progress;
    logic                             issue_active;
    logic [ADDR_W-1:0]                waddr;
    logic [ADDR_W-1:0]                raddr;
    logic [mpsm_pkg::CHAR_W-1:0]      rdata;
    logic                             hit;
    logic [LEN_W-1:0]                 hit_progress;
    logic                             hit_done;

    // Decode of the command taken at acceptance.
    always_comb
    begin
        do_load    = 1'b0;
        do_length  = 1'b0;
        do_restart = 1'b0;
        case (mpsm_pkg::command_t'(command))
            mpsm_pkg::CMD_LOAD:    do_load    = cmd.exec;
            mpsm_pkg::CMD_LENGTH:  do_length  = cmd.exec;
            mpsm_pkg::CMD_RESTART: do_restart = cmd.exec;
            default:
            begin
                do_load = 1'b0;
            end
        endcase
    end

    // Range checks on the slot and position, and length saturation.
    assign index_ext = mpsm_pkg::EXT_W'(word_index);
    assign pos_ext   = mpsm_pkg::EXT_W'(char_pos);
    assign len_ext   = mpsm_pkg::EXT_W'(word_length);
    assign index_ok  = index_ext < NUM_WORDS_V;
    assign pos_ok    = pos_ext < WORD_LEN_V;
    assign len_sat   = (len_ext > WORD_LEN_V) ? WORD_LEN_V : len_ext;

    // Read address of the slot being issued: its next expected character.
    assign issue_progress = progress_reg[slot_reg];
    assign issue_active   = issue_progress < length_reg[slot_reg];
    assign raddr          = {slot_reg, issue_progress[POS_W-1:0]};
    assign waddr          = {index_ext[SLOT_W-1:0], pos_ext[POS_W-1:0]};

    mpsm_ram #(
        .WIDTH (mpsm_pkg::CHAR_W),
        .DEPTH (RAM_DEPTH)
    ) u_pattern_ram (
        .clk   (clk),
        .we    (do_load && index_ok && pos_ok),
        .waddr (waddr),
        .wdata (char_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Compare stage: one slot per cycle, on the registered read data and slot of each read issue.
    assign hit          = cmp_valid_reg && cmp_active_reg && (rdata == char_reg);
    assign hit_progress = progress_reg[cmp_slot_reg] + LEN_W'(1);
    assign hit_done     = (hit_progress == length_reg[cmp_slot_reg]);

    // Match count with saturation.
    always_comb
    begin
        count_next = count_reg;
        if (do_restart)
        begin
            count_next = '0;
        end
        else if (hit && hit_done && (count_reg < mpsm_pkg::COUNT_MAX))
        begin
            count_next = count_reg + mpsm_pkg::COUNT_W'(1);
        end
    end

    // Per-slot length and progress.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                length_reg[i]   <= '0;
                progress_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                if (do_length && index_ok && (index_ext[SLOT_W-1:0] == SLOT_W'(i)))
                begin
                    length_reg[i] <= len_sat[LEN_W-1:0];
                end
                if (do_restart)
                begin
                    progress_reg[i] <= '0;
                end
                else if (do_length && index_ok &&
                         (index_ext[SLOT_W-1:0] == SLOT_W'(i)))
                begin
                    progress_reg[i] <= '0;
                end
                else if (hit && (cmp_slot_reg == SLOT_W'(i)))
                begin
                    progress_reg[i] <= hit_progress;
                end
            end
        end
    end

    // Scan sequencing, compare pipeline, count and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg       <= '0;
            cmp_valid_reg  <= 1'b0;
            cmp_active_reg <= 1'b0;
            cmp_slot_reg   <= '0;
            count_reg      <= '0;
            result_reg     <= '0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                slot_reg <= '0;
            end
            else if (cmd.scan_issue)
            begin
                slot_reg <= slot_reg + SLOT_W'(1);
            end
            cmp_valid_reg  <= cmd.scan_issue;
            cmp_active_reg <= issue_active;
            cmp_slot_reg   <= slot_reg;
            count_reg      <= count_next;
            if (cmd.out_load)
            begin
                result_reg <= count_next;
            end
        end
    end

    // Text character held for the whole scan.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            char_reg <= char_value;
        end
    end

    assign status.slot_last = (slot_reg == LAST_SLOT);
    assign match_count      = result_reg;

endmodule

FILE: rtl/core/multi_pattern_subsequence_matcher.sv
// Load, length and restart transactions leave the control in its idle state, so
// they can be taken on every clock while the result side keeps up. A text-character
// transaction walks the pattern slots one per cycle through the single read port
// of the pattern memory; the next transaction is taken only after the scan state
// has read all NUM_WORDS slots, the drain state has finished the last compare and
// the output state has presented the count. Every transaction returns one result,
// the match count after it. Pattern memory contents are undefined after reset;
// lengths, progress and the count reset to zero and need no clearing pass.
module multi_pattern_subsequence_matcher #(
    parameter int NUM_WORDS = 16,
    parameter int WORD_LEN  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [mpsm_pkg::CMD_W-1:0]        command,
    input  logic [mpsm_pkg::INDEX_W-1:0]      word_index,
    input  logic [mpsm_pkg::POS_IN_W-1:0]     char_pos,
    input  logic [mpsm_pkg::LEN_IN_W-1:0]     word_length,
    input  logic [mpsm_pkg::CHAR_W-1:0]       char_value,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [mpsm_pkg::COUNT_W-1:0]      match_count
);

    mpsm_pkg::ctrl_cmd_t    cmd;
    mpsm_pkg::ctrl_status_t status;

    // Sequencer.
    mpsm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // Storage and compare logic.
    mpsm_datapath #(
        .NUM_WORDS (NUM_WORDS),
        .WORD_LEN  (WORD_LEN)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .command     (command),
        .word_index  (word_index),
        .char_pos    (char_pos),
        .word_length (word_length),
        .char_value  (char_value),
        .match_count (match_count)
    );

endmodule

FILE: rtl/core/mpsm_checker.sv
// Port-level checker for the subsequence matcher, bound to the top level.
`include "assert_macros.svh"

module mpsm_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  logic                              item_stall,
    input  logic [mpsm_pkg::CMD_W-1:0]        command,
    input  logic                              result_valid,
    input  logic                              result_stall,
    input  logic [mpsm_pkg::COUNT_W-1:0]      match_count
);

    logic item_take;
    logic keeps_count;

    assign item_take   = item_valid && !item_stall;
    assign keeps_count = (command == mpsm_pkg::CMD_LOAD) ||
                         (command == mpsm_pkg::CMD_LENGTH);

    // A stalled result holds its count.
    `ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(match_count))

    // A restart transaction returns a zero count on the next cycle.
    `ASSERT_NEXT(a_restart_zero, clk, rst_n, item_take && (command == mpsm_pkg::CMD_RESTART), result_valid && (match_count == '0))

    // Load and length transactions return the unchanged count on the next cycle.
    `ASSERT_NEXT(a_load_keeps, clk, rst_n, item_take && keeps_count, result_valid && (match_count == $past(match_count)))

    // No transaction is taken while a result is stuck at the output.
    `ASSERT_IMPLIES(a_out_blocks_in, clk, rst_n, result_valid && result_stall, item_stall)

endmodule

bind multi_pattern_subsequence_matcher mpsm_checker u_mpsm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .command      (command),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .match_count  (match_count)
);

FILE: tb/multi_pattern_subsequence_matcher_tb.sv
// Testbench for the multi-pattern subsequence matcher with its own count predictor.
module multi_pattern_subsequence_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_WORDS    = 16;
    localparam int WORD_LEN     = 16;
    localparam int RANDOM_TXNS  = 900;
    localparam int DRAIN_CYCLES = NUM_WORDS + 13;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_START   = 3000;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        mpsm_pkg::command_t                 cmd;
        logic [mpsm_pkg::INDEX_W-1:0]       idx;
        logic [mpsm_pkg::POS_IN_W-1:0]      pos;
        logic [mpsm_pkg::LEN_IN_W-1:0]      len;
        logic [mpsm_pkg::CHAR_W-1:0]        chr;
        int unsigned                        gap;
    } matcher_txn_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               item_valid = 1'b0;
    logic                               item_stall;
    logic [mpsm_pkg::CMD_W-1:0]         command = mpsm_pkg::CMD_LOAD;
    logic [mpsm_pkg::INDEX_W-1:0]       word_index = '0;
    logic [mpsm_pkg::POS_IN_W-1:0]      char_pos = '0;
    logic [mpsm_pkg::LEN_IN_W-1:0]      word_length = '0;
    logic [mpsm_pkg::CHAR_W-1:0]        char_value = '0;
    logic                               result_valid;
    logic                               result_stall = 1'b0;
    logic [mpsm_pkg::COUNT_W-1:0]       match_count;

    // Predictor state: stored patterns, lengths, per-slot progress and the count.
    logic [mpsm_pkg::CHAR_W-1:0]        pat_chars [NUM_WORDS][WORD_LEN];
    logic [mpsm_pkg::LEN_IN_W-1:0]      pat_len [NUM_WORDS];
    logic [mpsm_pkg::LEN_IN_W-1:0]      pat_prog [NUM_WORDS];
    logic [mpsm_pkg::COUNT_W-1:0]       matched;

    // Stimulus bookkeeping.
    matcher_txn_t                       pending_txns[$];
    logic [mpsm_pkg::COUNT_W-1:0]       expected_counts[$];
    bit                                 loaded_pos [NUM_WORDS][WORD_LEN];
    bit                                 steady_feed;
    int                                 total_txns;
    int                                 sent_count;
    int                                 results_seen;
    int                                 fail_count;
    int                                 cmd_tally [4];
    int                                 peak_count;
    int                                 saturated_hits;
    int                                 cycle_count;
    int                                 hold_left;

    multi_pattern_subsequence_matcher #(
        .NUM_WORDS(NUM_WORDS),
        .WORD_LEN (WORD_LEN)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .command     (command),
        .word_index  (word_index),
        .char_pos    (char_pos),
        .word_length (word_length),
        .char_value  (char_value),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .match_count (match_count)
    );

    always #5 clk = ~clk;

    // Apply one accepted transaction to the predictor and return the count after it.
    function automatic logic [mpsm_pkg::COUNT_W-1:0] advance_matcher(
        input mpsm_pkg::command_t cmd,
        input logic [mpsm_pkg::INDEX_W-1:0] idx,
        input logic [mpsm_pkg::POS_IN_W-1:0] pos,
        input logic [mpsm_pkg::LEN_IN_W-1:0] len,
        input logic [mpsm_pkg::CHAR_W-1:0] chr
    );
        cmd_tally[cmd]++;
        case (cmd)
            mpsm_pkg::CMD_LOAD:
            begin
                if (idx < NUM_WORDS && pos < WORD_LEN)
                    pat_chars[idx][pos] = chr;
            end
            mpsm_pkg::CMD_LENGTH:
            begin
                if (idx < NUM_WORDS)
                begin
                    pat_len[idx] = (len > WORD_LEN) ? mpsm_pkg::LEN_IN_W'(WORD_LEN) : len;
                    pat_prog[idx] = '0;
                end
            end
            mpsm_pkg::CMD_TEXT:
            begin
                // Every slot still short of its length compares its next character.
                for (int s = 0; s < NUM_WORDS; s++)
                begin
                    if (pat_prog[s] < pat_len[s] && pat_chars[s][pat_prog[s]] == chr)
                    begin
                        pat_prog[s] = pat_prog[s] + 1'b1;
                        if (pat_prog[s] == pat_len[s])
                        begin
                            if (matched < mpsm_pkg::COUNT_MAX)
                                matched = matched + 1'b1;
                            else
                                saturated_hits++;
                        end
                    end
                end
            end
            default:
            begin
                for (int s = 0; s < NUM_WORDS; s++)
                    pat_prog[s] = '0;
                matched = '0;
            end
        endcase
        if (matched > peak_count)
            peak_count = matched;
        return matched;
    endfunction

    // Append one transaction to the stimulus queue with its idle gap.
    task automatic queue_txn(
        input mpsm_pkg::command_t cmd,
        input logic [mpsm_pkg::INDEX_W-1:0] idx,
        input logic [mpsm_pkg::POS_IN_W-1:0] pos,
        input logic [mpsm_pkg::LEN_IN_W-1:0] len,
        input logic [mpsm_pkg::CHAR_W-1:0] chr
    );
        matcher_txn_t t;
        t.cmd = cmd;
        t.idx = idx;
        t.pos = pos;
        t.len = len;
        t.chr = chr;
        t.gap = steady_feed ? 0 : $urandom_range(0, 9);
        if (cmd == mpsm_pkg::CMD_LOAD)
            loaded_pos[idx][pos] = 1'b1;
        pending_txns = {pending_txns, t};
    endtask

    // Text transactions carry random values in the fields that they do not use.
    task automatic queue_text(input logic [mpsm_pkg::CHAR_W-1:0] chr);
        queue_txn(mpsm_pkg::CMD_TEXT, mpsm_pkg::INDEX_W'($urandom),
                  mpsm_pkg::POS_IN_W'($urandom), mpsm_pkg::LEN_IN_W'($urandom), chr);
    endtask

    task automatic queue_restart();
        queue_txn(mpsm_pkg::CMD_RESTART, mpsm_pkg::INDEX_W'($urandom),
                  mpsm_pkg::POS_IN_W'($urandom), mpsm_pkg::LEN_IN_W'($urandom),
                  mpsm_pkg::CHAR_W'($urandom));
    endtask

    // A length of the pattern width or more goes out as any value that saturates to it.
    task automatic queue_length(input int slot, input int plen);
        logic [mpsm_pkg::LEN_IN_W-1:0] coded;
        coded = (plen >= WORD_LEN) ? mpsm_pkg::LEN_IN_W'($urandom_range(WORD_LEN, 31))
                                   : mpsm_pkg::LEN_IN_W'(plen);
        queue_txn(mpsm_pkg::CMD_LENGTH, mpsm_pkg::INDEX_W'(slot),
                  mpsm_pkg::POS_IN_W'($urandom), coded, mpsm_pkg::CHAR_W'($urandom));
    endtask

    // Mostly a four-letter alphabet so that patterns actually match.
    function automatic logic [mpsm_pkg::CHAR_W-1:0] pick_char(input bit wide);
        if (wide)
            return mpsm_pkg::CHAR_W'($urandom_range(0, 255));
        return mpsm_pkg::CHAR_W'(8'h61 + $urandom_range(0, 3));
    endfunction

    // Number of leading positions of a slot that hold a written character.
    function automatic int loaded_prefix(input int slot);
        int n;
        n = 0;
        while (n < WORD_LEN && loaded_pos[slot][n])
            n++;
        return n;
    endfunction

    // Load a whole pattern, then arm it with its length.
    task automatic program_pattern(input int slot, input int plen, input bit wide);
        for (int p = 0; p < plen; p++)
            queue_txn(mpsm_pkg::CMD_LOAD, mpsm_pkg::INDEX_W'(slot), mpsm_pkg::POS_IN_W'(p),
                      mpsm_pkg::LEN_IN_W'($urandom), pick_char(wide));
        queue_length(slot, plen);
    endtask

    // Free-running cycle count and the run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d of %0d transactions sent, %0d pending",
                     cycle_count, sent_count, total_txns, expected_counts.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Long receiver hold-off so that the block backs up and stalls its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (cycle_count == HOLD_START)
            hold_left <= HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Driver: predicts each accepted transaction and presents the next one.
    matcher_txn_t next_txn;
    bit           staged;
    int unsigned  send_wait;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid  <= 1'b0;
            command     <= mpsm_pkg::CMD_LOAD;
            word_index  <= '0;
            char_pos    <= '0;
            word_length <= '0;
            char_value  <= '0;
            staged = 1'b0;
            send_wait = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                expected_counts = {expected_counts,
                                   advance_matcher(mpsm_pkg::command_t'(command),
                                                   word_index, char_pos, word_length,
                                                   char_value)};
                sent_count++;
            end
            // The payload may only change once the current one is gone.
            if (!item_valid || !item_stall)
            begin
                if (!staged && pending_txns.size() != 0)
                begin
                    next_txn = pending_txns.pop_front();
                    staged = 1'b1;
                    send_wait = next_txn.gap;
                end
                if (staged && send_wait == 0)
                begin
                    command     <= next_txn.cmd;
                    word_index  <= next_txn.idx;
                    char_pos    <= next_txn.pos;
                    word_length <= next_txn.len;
                    char_value  <= next_txn.chr;
                    item_valid  <= 1'b1;
                    staged = 1'b0;
                end
                else
                begin
                    item_valid <= 1'b0;
                    if (staged)
                        send_wait--;
                end
            end
        end
    end

    // Monitor: checks each result against the oldest expected count.
    logic [mpsm_pkg::COUNT_W-1:0] want_count;
    int unsigned                  rcv_wait;
    bit                           rcv_steady;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            rcv_wait = 0;
            rcv_steady = 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (expected_counts.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected result transaction: match_count %0d", match_count);
                end
                else
                begin
                    want_count = expected_counts.pop_front();
                    if (match_count !== want_count)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("Result %0d: match_count expected %0d, got %0d",
                                     results_seen, want_count, match_count);
                    end
                end
                if (results_seen % 60 == 0)
                    rcv_steady = ($urandom_range(0, 3) == 0);
                rcv_wait = rcv_steady ? 0 : $urandom_range(0, 9);
            end
            if (hold_left != 0)
                result_stall <= 1'b1;
            else if (rcv_wait > 0)
            begin
                result_stall <= 1'b1;
                rcv_wait--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Stimulus, reset and end of run.
    int pick;
    int slot;
    int plen;
    int burst;
    int reach;

    initial
    begin
        for (int s = 0; s < NUM_WORDS; s++)
        begin
            pat_len[s] = '0;
            pat_prog[s] = '0;
            for (int p = 0; p < WORD_LEN; p++)
            begin
                pat_chars[s][p] = '0;
                loaded_pos[s][p] = 1'b0;
            end
        end
        matched = '0;
        for (int c = 0; c < 4; c++)
            cmd_tally[c] = 0;
        peak_count = 0;
        saturated_hits = 0;
        cycle_count = 0;
        sent_count = 0;
        results_seen = 0;
        fail_count = 0;
        steady_feed = 1'b0;

        // Directed: extreme characters, a repeat after completion, re-arming,
        // a zero-length slot, restart, and the last slot and position.
        queue_restart();
        queue_txn(mpsm_pkg::CMD_LOAD, 4'd0, 4'd0, 5'd31, 8'h00);
        queue_txn(mpsm_pkg::CMD_LOAD, 4'd0, 4'd1, 5'd0, 8'hFF);
        queue_txn(mpsm_pkg::CMD_LENGTH, 4'd0, 4'd15, 5'd2, 8'hFF);
        queue_text(8'hFF);
        queue_text(8'h00);
        queue_text(8'hFF);
        queue_text(8'h00);
        queue_txn(mpsm_pkg::CMD_LENGTH, 4'd0, 4'd0, 5'd2, 8'h00);
        queue_text(8'h00);
        queue_text(8'hFF);
        queue_txn(mpsm_pkg::CMD_LENGTH, 4'd15, 4'd0, 5'd0, 8'h00);
        queue_text(8'h00);
        queue_restart();
        queue_txn(mpsm_pkg::CMD_LOAD, 4'd15, 4'd15, 5'd16, 8'hAA);
        queue_txn(mpsm_pkg::CMD_LOAD, 4'd15, 4'd0, 5'd0, 8'h80);
        queue_txn(mpsm_pkg::CMD_LENGTH, 4'd15, 4'd7, 5'd1, 8'h7F);
        queue_text(8'h80);
        queue_text(8'h80);

        // Every slot armed with a one-letter pattern three times over drives the count
        // up towards its ceiling.
        for (int s = 0; s < NUM_WORDS; s++)
            program_pattern(s, 1, 1'b0);
        queue_text(pending_txns[pending_txns.size() - 2].chr);
        for (int s = 0; s < NUM_WORDS; s++)
            queue_length(s, 1);
        queue_text(pending_txns[pending_txns.size() - 2 * NUM_WORDS - 3].chr);
        for (int s = 0; s < NUM_WORDS; s++)
            program_pattern(s, 1, 1'b0);
        for (int c = 0; c < 4; c++)
            queue_text(mpsm_pkg::CHAR_W'(8'h61 + c));

        // Random sequences: mostly patterns and text, some restarts, re-arming and noise.
        while (pending_txns.size() < RANDOM_TXNS)
        begin
            steady_feed = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            slot = $urandom_range(0, NUM_WORDS - 1);
            if (pick < 30)
            begin
                reach = $urandom_range(0, 9);
                plen = (reach < 7) ? $urandom_range(1, 5)
                     : (reach < 9) ? $urandom_range(6, WORD_LEN - 1) : WORD_LEN;
                program_pattern(slot, plen, $urandom_range(0, 7) == 0);
            end
            else if (pick < 70)
            begin
                burst = $urandom_range(3, 12);
                for (int k = 0; k < burst; k++)
                    queue_text(pick_char($urandom_range(0, 9) == 0));
            end
            else if (pick < 78)
                queue_restart();
            else if (pick < 88)
            begin
                // Re-arm a slot with any length that its loaded characters cover.
                reach = loaded_prefix(slot);
                queue_length(slot, (reach == 0) ? 0 : $urandom_range(0, reach));
            end
            else if (pick < 94)
                queue_txn(mpsm_pkg::CMD_LOAD, mpsm_pkg::INDEX_W'(slot),
                          mpsm_pkg::POS_IN_W'($urandom), mpsm_pkg::LEN_IN_W'($urandom),
                          mpsm_pkg::CHAR_W'($urandom));
            else
            begin
                // A pattern load broken off before its length is set.
                burst = $urandom_range(1, WORD_LEN - 1);
                for (int p = 0; p < burst; p++)
                    queue_txn(mpsm_pkg::CMD_LOAD, mpsm_pkg::INDEX_W'(slot),
                              mpsm_pkg::POS_IN_W'(p), mpsm_pkg::LEN_IN_W'($urandom),
                              pick_char(1'b0));
            end
        end
        total_txns = pending_txns.size();

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (!(sent_count == total_txns && expected_counts.size() == 0))
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d transactions: %0d loads, %0d lengths, %0d text, %0d restarts.",
                 total_txns, cmd_tally[mpsm_pkg::CMD_LOAD], cmd_tally[mpsm_pkg::CMD_LENGTH],
                 cmd_tally[mpsm_pkg::CMD_TEXT], cmd_tally[mpsm_pkg::CMD_RESTART]);
        $display("Highest count %0d, %0d completions past the ceiling, %0d failures.",
                 peak_count, saturated_hits, fail_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
